### rtl/nearest_neighbor_point_orderer_macros.svh
// Assertion macros for the nearest-neighbor point orderer.
// Depends on nothing; included by the top level only.
`ifndef NEAREST_NEIGHBOR_POINT_ORDERER_MACROS_SVH
`define NEAREST_NEIGHBOR_POINT_ORDERER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define NNPO_CHECK(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define NNPO_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/nnpo_pkg.sv
// Shared constants and types for the nearest-neighbor point orderer.
// No dependencies; used by nnpo_dist_unit and the top level.
`timescale 1ns / 1ps

package nnpo_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 12;

    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int START_ROW_W = 12;
    localparam int OP_W        = 2;

    // Transaction kinds on the input stream
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_NEXT    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_OPTIMIZE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_ROW = 2'd3;

    // Control that travels with each slot through the distance pipeline
    typedef struct packed {
        logic valid;   // stage holds a slot read
        logic live;    // slot still holds an unemitted point
    } t_scan_tag;

endpackage

### rtl/nnpo_dist_unit.sv
// Two-stage squared-distance pipeline: absolute differences, then squares.
// Depends on nnpo_pkg for the scan tag type.
`timescale 1ns / 1ps

module nnpo_dist_unit #(
    parameter int COORD_BITS = nnpo_pkg::COORD_BITS_DEF,
    parameter int IDX_BITS   = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  nnpo_pkg::t_scan_tag       i_tag,
    input  logic [IDX_BITS-1:0]       i_idx,
    input  logic [COORD_BITS-1:0]     i_pt_x,
    input  logic [COORD_BITS-1:0]     i_pt_y,
    input  logic [COORD_BITS-1:0]     i_cur_x,
    input  logic [COORD_BITS-1:0]     i_cur_y,
    output nnpo_pkg::t_scan_tag       o_tag,
    output logic                      o_busy,
    output logic [IDX_BITS-1:0]       o_idx,
    output logic [COORD_BITS-1:0]     o_pt_x,
    output logic [COORD_BITS-1:0]     o_pt_y,
    output logic [2*COORD_BITS:0]     o_dist
);
    import nnpo_pkg::*;

    localparam int SQ_W = 2 * COORD_BITS;

    t_scan_tag               r_a_tag;
    logic [COORD_BITS-1:0]   r_a_dx;
    logic [COORD_BITS-1:0]   r_a_dy;
    logic [IDX_BITS-1:0]     r_a_idx;
    logic [COORD_BITS-1:0]   r_a_x;
    logic [COORD_BITS-1:0]   r_a_y;

    t_scan_tag               r_b_tag;
    logic [SQ_W-1:0]         r_b_sqx;
    logic [SQ_W-1:0]         r_b_sqy;
    logic [IDX_BITS-1:0]     r_b_idx;
    logic [COORD_BITS-1:0]   r_b_x;
    logic [COORD_BITS-1:0]   r_b_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
            r_b_tag <= '0;
        end else begin
            r_a_tag <= i_tag;
            r_b_tag <= r_a_tag;
        end
    end

    // Payload stages: no reset needed
    always_ff @(posedge i_clk) begin
        r_a_dx  <= (i_pt_x > i_cur_x) ? (i_pt_x - i_cur_x) : (i_cur_x - i_pt_x);
        r_a_dy  <= (i_pt_y > i_cur_y) ? (i_pt_y - i_cur_y) : (i_cur_y - i_pt_y);
        r_a_idx <= i_idx;
        r_a_x   <= i_pt_x;
        r_a_y   <= i_pt_y;

        r_b_sqx <= SQ_W'(r_a_dx) * SQ_W'(r_a_dx);
        r_b_sqy <= SQ_W'(r_a_dy) * SQ_W'(r_a_dy);
        r_b_idx <= r_a_idx;
        r_b_x   <= r_a_x;
        r_b_y   <= r_a_y;
    end

    assign o_tag  = r_b_tag;
    assign o_busy = r_a_tag.valid | r_b_tag.valid;
    assign o_idx  = r_b_idx;
    assign o_pt_x = r_b_x;
    assign o_pt_y = r_b_y;
    assign o_dist = (SQ_W + 1)'(r_b_sqx) + (SQ_W + 1)'(r_b_sqy);

endmodule

### rtl/nearest_neighbor_point_orderer.sv
// Nearest-neighbor point orderer: point table, raster cursor and output stage.
// Depends on nnpo_pkg, nnpo_dist_unit and nearest_neighbor_point_orderer_macros.svh.
`timescale 1ns / 1ps
//
//  Channel   Direction  Payload                                  Handshake
//  s_axis    in         tuser=op, tdata=point_x|point_y          tvalid/tready
//  m_axis    out        tdata=out_x|out_y, tuser=done_res        tvalid/tready
//  cfg       in         i_cfg_addr, i_cfg_wdata                  i_cfg_we, no wait
//
//  Load and restart transactions are accepted in the idle state. A raster next
//  request moves to the finish state and is ready again once its result enters
//  the output register. An optimize next request scans every filled slot: the
//  point memory has one read port, so the scan walks one slot per cycle, then
//  drains the read and distance stages. Reset is synchronous; the table needs
//  no clearing pass, since the fill count bounds every scan. A stalled output
//  holds in its register while new loads are accepted; a finished next request
//  waits until that register frees.

module nearest_neighbor_point_orderer #(
    parameter int MAX_POINTS = nnpo_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = nnpo_pkg::COORD_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Input stream
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: point_x, point_y (from bit 0), zero padded
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // tuser: op
    input  logic [nnpo_pkg::OP_W-1:0]               s_axis_tuser,
    // Output stream
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // tdata: out_x, out_y (from bit 0), zero padded
    output logic [((2*COORD_BITS+7)/8)*8-1:0]       m_axis_tdata,
    // tuser: done_res
    output logic                                    m_axis_tuser,
    // Configuration writes
    input  logic                                    i_cfg_we,
    input  logic [nnpo_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [nnpo_pkg::CFG_DATA_W-1:0]         i_cfg_wdata
);
    import nnpo_pkg::*;
    `include "nearest_neighbor_point_orderer_macros.svh"

    localparam int IW   = $clog2(MAX_POINTS);
    localparam int FW   = $clog2(MAX_POINTS + 1);
    localparam int PW   = 2 * COORD_BITS + 1;          // live bit over y over x
    localparam int DW   = 2 * COORD_BITS + 1;          // squared distance
    localparam int SUMW = COORD_BITS + 2;              // width + height
    localparam int BW   = 2 * COORD_BITS + 3;          // distance bound
    localparam int SW   = (COORD_BITS + 1 > CFG_DATA_W) ? COORD_BITS + 1 : CFG_DATA_W;
    localparam int TDW  = ((2 * COORD_BITS + 7) / 8) * 8;

    localparam logic [FW-1:0] FILL_MAX = FW'(MAX_POINTS);
    localparam logic [SW-1:0] AREA_LIM = SW'(1) << COORD_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state                   r_state;

    // Configuration
    logic                     r_opt;
    logic [CFG_DATA_W-1:0]    r_area_w;
    logic [CFG_DATA_W-1:0]    r_area_h;
    logic [START_ROW_W-1:0]   r_start_row;

    // Table and cursors
    logic [PW-1:0]            mem [MAX_POINTS];
    logic [PW-1:0]            r_rdata;
    logic [FW-1:0]            r_fill;
    logic [COORD_BITS-1:0]    r_cur_x;
    logic [COORD_BITS-1:0]    r_cur_y;
    logic [SW-1:0]            r_scan_x;
    logic [SW-1:0]            r_scan_y;

    // Scan control
    logic [FW-1:0]            r_idx;
    logic                     r_rd_valid;
    logic [IW-1:0]            r_rd_idx;
    logic [BW-1:0]            r_best;
    logic                     r_first_found;
    logic                     r_pick_found;
    logic [IW-1:0]            r_first_idx;
    logic [COORD_BITS-1:0]    r_first_x;
    logic [COORD_BITS-1:0]    r_first_y;
    logic [IW-1:0]            r_pick_idx;
    logic [COORD_BITS-1:0]    r_pick_x;
    logic [COORD_BITS-1:0]    r_pick_y;

    // Result waiting for the output register, and the output register
    logic [COORD_BITS-1:0]    r_res_x;
    logic [COORD_BITS-1:0]    r_res_y;
    logic                     r_res_done;
    logic                     r_out_valid;
    logic [COORD_BITS-1:0]    r_out_x;
    logic [COORD_BITS-1:0]    r_out_y;
    logic                     r_out_done;

    // Distance pipeline
    t_scan_tag                rd_tag;
    t_scan_tag                d_tag;
    logic                     d_busy;
    logic [IW-1:0]            d_idx;
    logic [COORD_BITS-1:0]    d_x;
    logic [COORD_BITS-1:0]    d_y;
    logic [DW-1:0]            d_dist;

    logic                     s_accept;
    logic [COORD_BITS-1:0]    in_x;
    logic [COORD_BITS-1:0]    in_y;
    logic [SW-1:0]            w_wide;
    logic [SW-1:0]            h_wide;
    logic [SW-1:0]            w_sat;
    logic [SW-1:0]            h_sat;
    logic [SUMW-1:0]          wh_sum;
    logic [2*SUMW-1:0]        wh_sq;
    logic                     raster_done;
    logic [SW-1:0]            n_scan_x;
    logic                     scan_issue;
    logic                     scan_end;
    logic                     out_load;
    logic [IW-1:0]            sel_idx;
    logic [COORD_BITS-1:0]    sel_x;
    logic [COORD_BITS-1:0]    sel_y;
    logic                     mem_we;
    logic [IW-1:0]            mem_waddr;
    logic [PW-1:0]            mem_wdata;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign in_x          = s_axis_tdata[COORD_BITS-1:0];
    assign in_y          = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

    // Clamp the drawing area to the coordinate range
    assign w_wide = SW'(r_area_w);
    assign h_wide = SW'(r_area_h);
    assign w_sat  = (w_wide > AREA_LIM) ? AREA_LIM : w_wide;
    assign h_sat  = (h_wide > AREA_LIM) ? AREA_LIM : h_wide;
    assign wh_sum = SUMW'(w_sat) + SUMW'(h_sat);
    assign wh_sq  = (2*SUMW)'(wh_sum) * (2*SUMW)'(wh_sum);

    // Raster cursor
    assign raster_done = (w_sat == '0) || (r_scan_y >= h_sat) || (r_scan_x >= w_sat);
    assign n_scan_x    = r_scan_x + SW'(1);

    // Scan walks slots 0 .. fill_count-1, one read per cycle
    assign scan_issue = (r_idx < r_fill);
    assign scan_end   = (r_state == ST_SCAN) && !scan_issue && !r_rd_valid && !d_busy;

    // Move the finished result into the output register once it is free
    assign out_load   = (r_state == ST_FINISH) && (!r_out_valid || m_axis_tready);

    // Nearest point if one is inside the bound, else the earliest live one
    assign sel_idx = r_pick_found ? r_pick_idx : r_first_idx;
    assign sel_x   = r_pick_found ? r_pick_x   : r_first_x;
    assign sel_y   = r_pick_found ? r_pick_y   : r_first_y;

    // Loads and removals never overlap a scan read, so no forwarding is needed
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_fill[IW-1:0];
        mem_wdata = {1'b1, in_y, in_x};
        if (s_accept && (s_axis_tuser == OP_LOAD) && (r_fill < FILL_MAX)) begin
            mem_we = 1'b1;
        end else if (scan_end && r_first_found) begin
            mem_we    = 1'b1;
            mem_waddr = sel_idx;
            mem_wdata = {1'b0, sel_y, sel_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[r_idx[IW-1:0]];
    end

    assign rd_tag.valid = r_rd_valid;
    assign rd_tag.live  = r_rdata[PW-1];

    nnpo_dist_unit #(
        .COORD_BITS (COORD_BITS),
        .IDX_BITS   (IW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (rd_tag),
        .i_idx   (r_rd_idx),
        .i_pt_x  (r_rdata[COORD_BITS-1:0]),
        .i_pt_y  (r_rdata[2*COORD_BITS-1:COORD_BITS]),
        .i_cur_x (r_cur_x),
        .i_cur_y (r_cur_y),
        .o_tag   (d_tag),
        .o_busy  (d_busy),
        .o_idx   (d_idx),
        .o_pt_x  (d_x),
        .o_pt_y  (d_y),
        .o_dist  (d_dist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_opt         <= 1'b0;
            r_area_w      <= '0;
            r_area_h      <= '0;
            r_start_row   <= '0;
            r_fill        <= '0;
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_scan_x      <= '0;
            r_scan_y      <= '0;
            r_idx         <= '0;
            r_rd_valid    <= 1'b0;
            r_first_found <= 1'b0;
            r_pick_found  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_OPTIMIZE:  r_opt       <= i_cfg_wdata[0];
                    CFG_WIDTH:     r_area_w    <= i_cfg_wdata;
                    CFG_HEIGHT:    r_area_h    <= i_cfg_wdata;
                    CFG_START_ROW: r_start_row <= i_cfg_wdata[START_ROW_W-1:0];
                    default: ;
                endcase
            end

            // Reload the output with a finished result, else drop it once taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // A slot read is in flight for every index issued during the scan
            r_rd_valid <= (r_state == ST_SCAN) && scan_issue;

            unique case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        unique case (s_axis_tuser)
                            OP_LOAD: begin
                                if (r_fill < FILL_MAX) begin
                                    r_fill <= r_fill + FW'(1);
                                end
                            end
                            OP_NEXT: begin
                                if (r_opt) begin
                                    r_idx         <= '0;
                                    r_best        <= wh_sq[BW-1:0];
                                    r_first_found <= 1'b0;
                                    r_pick_found  <= 1'b0;
                                    r_state       <= ST_SCAN;
                                end else begin
                                    if (raster_done) begin
                                        r_res_x    <= '0;
                                        r_res_y    <= '0;
                                        r_res_done <= 1'b1;
                                    end else begin
                                        r_res_x    <= r_scan_x[COORD_BITS-1:0];
                                        r_res_y    <= r_scan_y[COORD_BITS-1:0];
                                        r_res_done <= 1'b0;
                                        // Advance x, wrap to the next row at the width
                                        if (n_scan_x >= w_sat) begin
                                            r_scan_x <= '0;
                                            r_scan_y <= r_scan_y + SW'(1);
                                        end else begin
                                            r_scan_x <= n_scan_x;
                                        end
                                    end
                                    r_state <= ST_FINISH;
                                end
                            end
                            OP_RESTART: begin
                                r_fill   <= '0;
                                r_cur_x  <= '0;
                                r_cur_y  <= '0;
                                r_scan_x <= '0;
                                r_scan_y <= SW'(r_start_row);
                            end
                            default: ;
                        endcase
                    end
                end

                ST_SCAN: begin
                    if (scan_issue) begin
                        r_idx      <= r_idx + FW'(1);
                        r_rd_idx   <= r_idx[IW-1:0];
                    end

                    // Compare stage: keep the earliest live slot and the strict minimum
                    if (d_tag.valid && d_tag.live) begin
                        if (!r_first_found) begin
                            r_first_found <= 1'b1;
                            r_first_idx   <= d_idx;
                            r_first_x     <= d_x;
                            r_first_y     <= d_y;
                        end
                        if (BW'(d_dist) < r_best) begin
                            r_best       <= BW'(d_dist);
                            r_pick_found <= 1'b1;
                            r_pick_idx   <= d_idx;
                            r_pick_x     <= d_x;
                            r_pick_y     <= d_y;
                        end
                    end

                    if (scan_end) begin
                        if (r_first_found) begin
                            r_cur_x    <= sel_x;
                            r_cur_y    <= sel_y;
                            r_res_x    <= sel_x;
                            r_res_y    <= sel_y;
                            r_res_done <= 1'b0;
                        end else begin
                            r_res_x    <= '0;
                            r_res_y    <= '0;
                            r_res_done <= 1'b1;
                        end
                        r_state <= ST_FINISH;
                    end
                end

                ST_FINISH: begin
                    // Hold until the output register is free
                    if (out_load) begin
                        r_out_x     <= r_res_x;
                        r_out_y     <= r_res_y;
                        r_out_done  <= r_res_done;
                        r_state     <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDW'({r_out_y, r_out_x});
    assign m_axis_tuser  = r_out_done;

    `NNPO_CHECK(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_MAX,
                "fill count beyond table depth")
    `NNPO_CHECK(a_pick_in_table, i_clk, i_rst_n, scan_end && r_first_found,
                FW'(sel_idx) < r_fill, "chosen slot outside filled table")
    `NNPO_CHECK(a_done_zero, i_clk, i_rst_n, r_out_valid && r_out_done,
                (r_out_x == '0) && (r_out_y == '0), "done result carries coordinates")
    `NNPO_CHECK_NEXT(a_next_leaves_idle, i_clk, i_rst_n, s_accept && (s_axis_tuser == OP_NEXT),
                     r_state != ST_IDLE, "next request produced no work")

endmodule

### dv/nearest_neighbor_point_orderer_tb.sv
// Self-checking testbench for nearest_neighbor_point_orderer: directed and random streams.
// Depends on nnpo_pkg and the RTL top level; predicts each emitted point in-line.
`timescale 1ns / 1ps

module nearest_neighbor_point_orderer_tb;
    import nnpo_pkg::*;

    localparam int MAX_PTS = MAX_POINTS_DEF;
    localparam int CB = COORD_BITS_DEF;
    localparam int DATA_W = ((2*CB+7)/8)*8;
    localparam int AREA_LIMIT = 1 << CB;
    localparam int COORD_MAX = (1 << CB) - 1;
    localparam int EXTENT_MAX = (1 << CFG_DATA_W) - 1;

    // Op code 3 has no meaning; the block must ignore it
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    localparam int RANDOM_ITEMS = 1150;
    localparam int HOLD_CYCLES = 400;
    // Covers the longest optimize scan over a full table, with margin
    localparam int DRAIN_CYCLES = MAX_PTS + 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic          done;
        logic [CB-1:0] y;
        logic [CB-1:0] x;
    } t_plot_point;

    // DUT stimulus, all known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic [DATA_W-1:0]     s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = OP_LOAD;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = CFG_OPTIMIZE;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    wire                   s_axis_tready;
    wire                   m_axis_tvalid;
    wire [DATA_W-1:0]      m_axis_tdata;
    wire                   m_axis_tuser;

    nearest_neighbor_point_orderer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // point_x [11:0], point_y [23:12]
        .s_axis_tuser  (s_axis_tuser),   // op
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // out_x [11:0], out_y [23:12]
        .m_axis_tuser  (m_axis_tuser),   // done_res
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: point table, plotter position, raster cursor and
    // a shadow of the configuration registers.
    // ------------------------------------------------------------------
    logic [CB-1:0] tbl_x [MAX_PTS];
    logic [CB-1:0] tbl_y [MAX_PTS];
    bit            tbl_live [MAX_PTS];
    int            tbl_fill = 0;
    logic [CB-1:0] pos_x = '0;
    logic [CB-1:0] pos_y = '0;
    int            scan_col = 0;
    int            scan_row = 0;

    bit            cfg_optimize = 1'b0;
    int            cfg_width = 0;
    int            cfg_height = 0;
    int            cfg_start_row = 0;

    t_plot_point   expected_points[$];

    // Run bookkeeping
    int  n_loads = 0;
    int  n_nexts = 0;
    int  n_restarts = 0;
    int  n_ignored = 0;
    int  n_settings = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  stalled_cycles = 0;

    // Traffic shaping knobs, set by the test tasks
    bit  sender_burst = 1'b0;
    bit  sink_burst = 1'b0;
    bit  hold_req = 1'b0;

    // Area extents above 2^CB behave as 2^CB
    function automatic longint clamp_extent(input int v);
        return (v > AREA_LIMIT) ? longint'(AREA_LIMIT) : longint'(v);
    endfunction

    // Greedy pick: strictly nearest inside the (w+h)^2 bound, earliest on
    // ties, earliest live slot when nothing qualifies.
    function automatic t_plot_point pick_nearest();
        longint      w, h, best, dx, dy, sq_dist, px, py;
        int          i, pick, first;
        t_plot_point res;
        w = clamp_extent(cfg_width);
        h = clamp_extent(cfg_height);
        best = (w + h) * (w + h);
        pick = -1;
        first = -1;
        res = '{done: 1'b1, y: '0, x: '0};
        for (i = 0; i < tbl_fill; i++) begin
            if (tbl_live[i]) begin
                if (first < 0)
                    first = i;
                px = longint'(tbl_x[i]);
                py = longint'(tbl_y[i]);
                dx = (px > longint'(pos_x)) ? px - longint'(pos_x) : longint'(pos_x) - px;
                dy = (py > longint'(pos_y)) ? py - longint'(pos_y) : longint'(pos_y) - py;
                sq_dist = dx * dx + dy * dy;
                if (sq_dist < best) begin
                    best = sq_dist;
                    pick = i;
                end
            end
        end
        if (first >= 0) begin
            if (pick < 0)
                pick = first;
            pos_x = tbl_x[pick];
            pos_y = tbl_y[pick];
            tbl_live[pick] = 1'b0;
            res = '{done: 1'b0, y: pos_y, x: pos_x};
        end
        return res;
    endfunction

    // Raster cursor: x fastest, rows from the start row up to height-1
    function automatic t_plot_point step_raster();
        longint      w, h;
        t_plot_point res;
        w = clamp_extent(cfg_width);
        h = clamp_extent(cfg_height);
        res = '{done: 1'b1, y: '0, x: '0};
        if (w != 0 && scan_row < h && scan_col < w) begin
            res = '{done: 1'b0, y: scan_row[CB-1:0], x: scan_col[CB-1:0]};
            scan_col++;
            if (scan_col >= w) begin
                scan_col = 0;
                scan_row++;
            end
        end
        return res;
    endfunction

    // Advance the predictor by one accepted transaction; returns 1 when it emits
    function automatic bit predict_transaction(input logic [OP_W-1:0] op,
                                               input logic [CB-1:0] px,
                                               input logic [CB-1:0] py,
                                               output t_plot_point res);
        res = '0;
        case (op)
            OP_LOAD: begin
                // Slots are never reused before a restart
                if (tbl_fill < MAX_PTS) begin
                    tbl_x[tbl_fill] = px;
                    tbl_y[tbl_fill] = py;
                    tbl_live[tbl_fill] = 1'b1;
                    tbl_fill++;
                end
            end
            OP_NEXT: begin
                res = cfg_optimize ? pick_nearest() : step_raster();
                return 1'b1;
            end
            OP_RESTART: begin
                foreach (tbl_live[i])
                    tbl_live[i] = 1'b0;
                tbl_fill = 0;
                pos_x = '0;
                pos_y = '0;
                scan_col = 0;
                scan_row = cfg_start_row;
            end
            default: begin
            end
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Input side: offer one transaction after a random gap (none in burst mode),
    // hold it until the block takes it, then update the prediction.
    // ------------------------------------------------------------------
    task automatic send_transaction(input logic [OP_W-1:0] op,
                                    input logic [CB-1:0] px,
                                    input logic [CB-1:0] py);
        int          gap;
        bit          dropped;
        t_plot_point res;
        gap = sender_burst ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {py, px};
        do @(posedge i_clk); while (!s_axis_tready);
        dropped = (op == OP_LOAD) && (tbl_fill == MAX_PTS);
        if (predict_transaction(op, px, py, res))
            expected_points.push_back(res);
        case (op)
            OP_LOAD:    if (dropped) n_ignored++; else n_loads++;
            OP_NEXT:    n_nexts++;
            OP_RESTART: n_restarts++;
            default:    n_ignored++;
        endcase
    endtask

    // Write all four registers back to back; the block must be idle
    task automatic apply_config(input bit optimize, input int width, input int height,
                                input int start_row);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_OPTIMIZE;
        i_cfg_wdata <= CFG_DATA_W'(optimize);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_WIDTH;
        i_cfg_wdata <= CFG_DATA_W'(width);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_HEIGHT;
        i_cfg_wdata <= CFG_DATA_W'(height);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_START_ROW;
        i_cfg_wdata <= CFG_DATA_W'(start_row[START_ROW_W-1:0]);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_optimize  = optimize;
        cfg_width     = width & EXTENT_MAX;
        cfg_height    = height & EXTENT_MAX;
        cfg_start_row = start_row & COORD_MAX;
        n_settings++;
    endtask

    // Drop valid, drain every pending point, then let a full scan's worth
    // of cycles pass so a trailing load or restart has certainly landed.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CB-1:0] pick_coord(input bit clustered);
        return clustered ? CB'($urandom_range(0, 63)) : CB'($urandom_range(0, COORD_MAX));
    endfunction

    // Picks an area extent, the out-of-range register values included
    function automatic int pick_extent(input bit optimize);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return AREA_LIMIT;
            2:       return EXTENT_MAX;
            3:       return $urandom_range(AREA_LIMIT + 1, EXTENT_MAX);
            default: return optimize ? $urandom_range(1, AREA_LIMIT) : $urandom_range(1, 8);
        endcase
    endfunction

    // Occasional stray transaction of any kind with random payload
    task automatic maybe_send_noise();
        if ($urandom_range(0, 19) == 0)
            send_transaction(OP_W'($urandom_range(0, 3)), pick_coord(1'b0), pick_coord(1'b0));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers give a zero-width raster: done at once; op 3 ignored
    task automatic test_reset_defaults();
        send_transaction(OP_NEXT, '0, '0);
        send_transaction(OP_UNKNOWN, CB'(12'hABC), CB'(12'h123));
        settle_block();
    endtask

    // Raster order, repeated done, start row on restart, oversized area
    task automatic test_raster_scan();
        apply_config(1'b0, 2, 2, 0);
        send_transaction(OP_RESTART, '0, '0);
        repeat (6) send_transaction(OP_NEXT, '0, '0);
        settle_block();
        apply_config(1'b0, 2, 2, 1);
        send_transaction(OP_RESTART, '0, '0);
        send_transaction(OP_NEXT, '0, '0);
        settle_block();
        apply_config(1'b0, EXTENT_MAX, EXTENT_MAX, COORD_MAX);
        send_transaction(OP_RESTART, '0, '0);
        repeat (2) send_transaction(OP_NEXT, '0, '0);
        settle_block();
    endtask

    // Nearest-first order with a tie, coordinate extremes, empty table,
    // no point inside the bound, and a mode switch between requests
    task automatic test_nearest_order();
        apply_config(1'b1, AREA_LIMIT, AREA_LIMIT, 0);
        send_transaction(OP_RESTART, '0, '0);
        send_transaction(OP_LOAD, CB'(COORD_MAX), CB'(COORD_MAX));
        send_transaction(OP_LOAD, CB'(3), CB'(4));
        send_transaction(OP_LOAD, CB'(4), CB'(3));
        send_transaction(OP_LOAD, '0, '0);
        repeat (5) send_transaction(OP_NEXT, '0, '0);
        settle_block();
        // Zero area: the bound is zero so the earliest live point is taken
        apply_config(1'b1, 0, 0, 0);
        send_transaction(OP_RESTART, '0, '0);
        send_transaction(OP_LOAD, CB'(7), CB'(7));
        send_transaction(OP_LOAD, CB'(1), CB'(1));
        send_transaction(OP_NEXT, '0, '0);
        settle_block();
        // Raster cursor and plotter position persist across a mode switch
        apply_config(1'b0, 2, 2, 0);
        send_transaction(OP_NEXT, '0, '0);
        settle_block();
        apply_config(1'b1, 0, 0, 0);
        send_transaction(OP_NEXT, '0, '0);
        settle_block();
    endtask

    // Overfill the table, drain part of it, then reuse slots after restart
    task automatic test_table_full();
        apply_config(1'b1, AREA_LIMIT, AREA_LIMIT, 0);
        send_transaction(OP_RESTART, '0, '0);
        repeat (MAX_PTS + 6)
            send_transaction(OP_LOAD, pick_coord(1'b0), pick_coord(1'b0));
        repeat (6) send_transaction(OP_NEXT, '0, '0);
        send_transaction(OP_RESTART, '0, '0);
        repeat (2) send_transaction(OP_LOAD, pick_coord(1'b1), pick_coord(1'b1));
        repeat (3) send_transaction(OP_NEXT, '0, '0);
        settle_block();
    endtask

    // Receiver holds off for a long stretch while requests keep coming,
    // so the output register and the finished scan back up into the input
    task automatic test_output_backpressure();
        apply_config(1'b1, AREA_LIMIT, AREA_LIMIT, 0);
        sender_burst = 1'b1;
        hold_req = 1'b1;
        send_transaction(OP_RESTART, '0, '0);
        repeat (10) send_transaction(OP_LOAD, pick_coord(1'b1), pick_coord(1'b1));
        repeat (12) send_transaction(OP_NEXT, '0, '0);
        sender_burst = 1'b0;
        settle_block();
    endtask

    // One batch: usually a restart, some loads, then requests that usually drain
    // small tables and hit done, with stray transactions mixed in
    task automatic run_point_batch();
        int r, n, requests;
        bit clustered;
        r = $urandom_range(0, 99);
        n = (r < 85) ? $urandom_range(1, 12) :
            (r < 97) ? $urandom_range(13, 40) : $urandom_range(60, MAX_PTS);
        clustered = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) != 0)
            send_transaction(OP_RESTART, pick_coord(1'b0), pick_coord(1'b0));
        repeat (n) begin
            maybe_send_noise();
            send_transaction(OP_LOAD, pick_coord(clustered), pick_coord(clustered));
        end
        // Keep large tables cheap: only part of them is drained
        requests = (n > 40) ? 24 : n + $urandom_range(0, 2);
        repeat (requests) begin
            if ($urandom_range(0, 9) == 0)
                send_transaction(OP_LOAD, pick_coord(clustered), pick_coord(clustered));
            maybe_send_noise();
            send_transaction(OP_NEXT, pick_coord(1'b0), pick_coord(1'b0));
        end
    endtask

    task automatic test_random_traffic();
        int base;
        int sr_pick;
        bit optimize;
        base = n_loads + n_nexts + n_restarts;
        while (n_loads + n_nexts + n_restarts - base < RANDOM_ITEMS) begin
            optimize = 1'($urandom_range(0, 1));
            sr_pick = $urandom_range(0, 3);
            apply_config(optimize, pick_extent(optimize), pick_extent(optimize),
                         (sr_pick == 0) ? 0 : (sr_pick == 1) ? COORD_MAX :
                         $urandom_range(0, 6));
            sender_burst = ($urandom_range(0, 3) == 0);
            sink_burst   = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 5)) run_point_batch();
            settle_block();
        end
        sender_burst = 1'b0;
        sink_burst   = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: draw a stall per result; a pending hold request turns
    // the next stall into one long stretch counted here.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                gap = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                gap = sink_burst ? 0 : $urandom_range(0, 14);
            end
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Compare every accepted result against the oldest predicted point
    always @(posedge i_clk) begin : result_check
        t_plot_point want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result x=%0d y=%0d done=%0b", $realtime,
                             m_axis_tdata[CB-1:0], m_axis_tdata[2*CB-1:CB], m_axis_tuser);
            end else begin
                want = expected_points.pop_front();
                if (m_axis_tdata[CB-1:0] !== want.x || m_axis_tdata[2*CB-1:CB] !== want.y ||
                    m_axis_tuser !== want.done) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: expected x=%0d y=%0d done=%0b, actual x=%0d y=%0d done=%0b",
                                 $realtime, want.x, want.y, want.done, m_axis_tdata[CB-1:0],
                                 m_axis_tdata[2*CB-1:CB], m_axis_tuser);
                end
            end
        end
    end

    // Abort when neither side moves a transaction for too long
    always @(posedge i_clk) begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results pending",
                     stalled_cycles, expected_points.size());
            $display("nearest_neighbor_point_orderer verification failed");
            $finish;
        end
    end

    initial begin : main_sequence
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_raster_scan();
        test_nearest_order();
        test_table_full();
        test_output_backpressure();
        test_random_traffic();
        settle_block();

        $display("covered %0d loads, %0d next requests, %0d restarts, %0d ignored, %0d settings",
                 n_loads, n_nexts, n_restarts, n_ignored, n_settings);
        $display("checked %0d emitted points, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("nearest_neighbor_point_orderer verification clean");
        end else begin
            $display("nearest_neighbor_point_orderer verification failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/nnpo_pkg.sv
rtl/nnpo_dist_unit.sv
rtl/nearest_neighbor_point_orderer.sv
dv/nearest_neighbor_point_orderer_tb.sv
